// File: rtl/core/tirt_pkg.sv
// ----------------------------------------------------------------------------
// Transaction ID remap table package
// Shared constants, codes and types for the remap table and its cells.
// ----------------------------------------------------------------------------
package tirt_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
   localparam int LEVELS        = $clog2(TABLE_ENTRIES);

   // Field widths
   localparam int ID_W     = 16;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;

   // Command codes
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   // One stored mapping
   typedef struct packed {
      logic [ID_W-1:0]   mapped_id;
      logic [ID_W-1:0]   original_id;
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
   } entry_type;

   // Controls broadcast to every cell
   typedef struct packed {
      logic compare;
      logic insert_go;
      logic release_go;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } state_type;

endpackage

// File: rtl/core/tirt_cell.sv
// ----------------------------------------------------------------------------
// Remap table cell
// Holds one mapping, compares it against the lookup id, loads a new mapping
// when it is the first empty cell, and takes its upper neighbour's mapping
// when an entry at or below it is released.
// ----------------------------------------------------------------------------
module tirt_cell
   import tirt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cell_ctrl_type   ctrl,
   input  logic            shift,
   input  logic [ID_W-1:0] lookup_id,
   input  entry_type       new_entry,
   input  entry_type       up_entry,
   input  logic            up_valid,
   input  logic            below_valid,
   output entry_type       entry,
   output logic            valid,
   output logic            match
);

   logic      valid_ff;
   logic      match_ff;
   entry_type entry_ff;
   logic      load;
   logic      take_up;

   // Load only into the first empty cell; shift down on release
   assign load    = ctrl.insert_go && !valid_ff && below_valid;
   assign take_up = ctrl.release_go && shift;

   // Control state: occupancy and compare result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctrl.compare) begin
            match_ff <= valid_ff && (entry_ff.mapped_id == lookup_id);
         end
         if (take_up) begin
            valid_ff <= up_valid;
         end else if (load) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      if (take_up) begin
         entry_ff <= up_entry;
      end else if (load) begin
         entry_ff <= new_entry;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

// File: rtl/core/tirt_select.sv
// ----------------------------------------------------------------------------
// Remap table hit selection
// Finds the oldest matching cell from the registered match bits, builds the
// shift enables for compaction and picks out the released mapping.
// ----------------------------------------------------------------------------
module tirt_select
   import tirt_pkg::*;
(
   input  logic [TABLE_ENTRIES-1:0] match_vec,
   input  entry_type                cell_entry [TABLE_ENTRIES],
   output logic                     hit,
   output logic [TABLE_ENTRIES-1:0] shift_vec,
   output entry_type                hit_entry
);

   logic [TABLE_ENTRIES-1:0] pfx;
   logic [TABLE_ENTRIES-1:0] first;
   entry_type                sel;

   // Prefix OR: a cell shifts when any match sits at or below it
   always_comb begin
      pfx = match_vec;
      for (int s = 0; s < LEVELS; s++) begin
         pfx = pfx | (pfx << (1 << s));
      end
   end

   assign first = match_vec & ~(pfx << 1);

   // Gather the oldest hit's mapping
   always_comb begin
      sel = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (first[i]) begin
            sel = sel | cell_entry[i];
         end
      end
   end

   assign hit       = pfx[TABLE_ENTRIES-1];
   assign shift_vec = pfx;
   assign hit_entry = sel;

endmodule

// File: rtl/core/transaction_id_remap_table.sv
// An accepted request passes the compare state, then the apply state, which loads the result and
// waits while an untaken result holds the output register. A new request is taken when idle or
// as the last one applies, so the compare across all cells and the chain shift or load alternate.
// A result waiting in the output register does not block the next request's compare.
// Reset (synchronous, active high) empties the table, zeroes the id counter and
// the live count; cell payload is not cleared.
// ----------------------------------------------------------------------------
// Transaction ID remap table
// Keeps live mappings packed oldest first in a chain of cells, hands out
// 16-bit mapped ids on insert and restores client data on release.
// ----------------------------------------------------------------------------
module transaction_id_remap_table
   import tirt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [ID_W-1:0]     req_original_id,
   input  logic [ADDR_W-1:0]   req_client_address,
   input  logic [PORT_W-1:0]   req_client_port,
   input  logic [ID_W-1:0]     req_lookup_id,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_assigned_id,
   output logic [ID_W-1:0]     rsp_restored_id,
   output logic [ADDR_W-1:0]   rsp_restored_address,
   output logic [PORT_W-1:0]   rsp_restored_port,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   state_type                state_ff, state_in;
   cell_ctrl_type            ctrl;
   logic                     ready_int;
   logic                     go;
   logic                     apply_go;

   // Captured request
   logic                     cmd_ff;
   logic [ID_W-1:0]          orig_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [PORT_W-1:0]        port_ff;
   logic [ID_W-1:0]          lookup_ff;

   logic [ID_W-1:0]          next_id_ff;
   logic [COUNT_W-1:0]       count_ff, count_in;

   // Result register
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [ID_W-1:0]          assigned_ff, assigned_in;
   entry_type                restored_ff, restored_in;
   logic [OCC_W-1:0]         occ_ff;

   // Cell chain
   entry_type                cell_entry [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] cell_valid;
   logic [TABLE_ENTRIES-1:0] cell_match;
   logic [TABLE_ENTRIES-1:0] shift_vec;
   entry_type                new_entry;
   entry_type                hit_entry;
   logic                     hit;
   logic                     full;

   assign go       = !rsp_valid_ff || rsp_ready;
   assign full     = cell_valid[TABLE_ENTRIES-1];
   assign apply_go = (state_ff == ST_APPLY) && go;

   // Sequencer: next state and cell controls
   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      ready_int = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ready_int = 1'b1;
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            if (go) begin
               ready_int       = 1'b1;
               ctrl.insert_go  = (cmd_ff == CMD_INSERT);
               ctrl.release_go = (cmd_ff == CMD_RELEASE);
               state_in        = req_valid ? ST_COMPARE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (req_valid && ready_int) begin
         cmd_ff    <= req_command;
         orig_ff   <= req_original_id;
         addr_ff   <= req_client_address;
         port_ff   <= req_client_port;
         lookup_ff <= req_lookup_id;
      end
   end

   assign new_entry = '{mapped_id: next_id_ff, original_id: orig_ff,
                        address: addr_ff, port: port_ff};

   // Build the chain of cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      entry_type up_entry;
      logic      up_valid;
      logic      below_valid;

      if (i == TABLE_ENTRIES - 1) begin : g_top
         assign up_entry = '0;
         assign up_valid = 1'b0;
      end else begin : g_mid
         assign up_entry = cell_entry[i+1];
         assign up_valid = cell_valid[i+1];
      end

      if (i == 0) begin : g_bottom
         assign below_valid = 1'b1;
      end else begin : g_upper
         assign below_valid = cell_valid[i-1];
      end

      tirt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .shift       (shift_vec[i]),
         .lookup_id   (lookup_ff),
         .new_entry   (new_entry),
         .up_entry    (up_entry),
         .up_valid    (up_valid),
         .below_valid (below_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i])
      );
   end

   tirt_select u_select (
      .match_vec  (cell_match),
      .cell_entry (cell_entry),
      .hit        (hit),
      .shift_vec  (shift_vec),
      .hit_entry  (hit_entry)
   );

   // Work out the result of the item being applied
   always_comb begin
      status_in   = STATUS_OK;
      assigned_in = '0;
      restored_in = '0;
      count_in    = count_ff;
      if (cmd_ff == CMD_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            assigned_in = next_id_ff;
            count_in    = count_ff + 1'b1;
         end
      end else begin
         if (hit) begin
            restored_in           = hit_entry;
            restored_in.mapped_id = '0;
            count_in              = count_ff - 1'b1;
         end else begin
            status_in = STATUS_NOT_FOUND;
         end
      end
   end

   // Advance counters on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= '0;
         count_ff   <= '0;
      end else if (apply_go) begin
         count_ff <= count_in;
         if (cmd_ff == CMD_INSERT && !full) begin
            next_id_ff <= next_id_ff + 1'b1;
         end
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (apply_go) begin
         status_ff   <= status_in;
         assigned_ff <= assigned_in;
         restored_ff <= restored_in;
         occ_ff      <= OCC_W'(count_in);
      end
   end

   assign req_ready            = ready_int;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_assigned_id      = assigned_ff;
   assign rsp_restored_id      = restored_ff.original_id;
   assign rsp_restored_address = restored_ff.address;
   assign rsp_restored_port    = restored_ff.port;
   assign rsp_occupancy        = occ_ff;

`ifndef SYNTH
   // Live count never exceeds the table
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_ENTRIES))
      else $error("live count above table size");

   // Live cells stay packed from the bottom of the chain
   assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("cell chain not packed");

   // Live count agrees with the occupied cells
   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("live count out of step with cells");

   // A committed insert advances the id counter by one
   assert property (@(posedge clock) disable iff (reset)
      (apply_go && cmd_ff == CMD_INSERT && !full)
      |=> next_id_ff == ID_W'($past(next_id_ff) + 1'b1))
      else $error("id counter did not advance");
`endif

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Transaction ID remap table testbench
// Drives inserts and releases over the request channel and keeps its own
// copy of the live mappings and the id counter. Every response transfer is
// compared field by field with the outcome owed for the oldest accepted
// request. Covers empty and full tables, release misses and a long response
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import tirt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 1260;
   localparam int unsigned SETTLE_CYCLES = 8;

   // One response as the block should present it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     assigned_id;
      logic [ID_W-1:0]     restored_id;
      logic [ADDR_W-1:0]   restored_address;
      logic [PORT_W-1:0]   restored_port;
      logic [OCC_W-1:0]    occupancy;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_command;
   logic [ID_W-1:0]     req_original_id;
   logic [ADDR_W-1:0]   req_client_address;
   logic [PORT_W-1:0]   req_client_port;
   logic [ID_W-1:0]     req_lookup_id;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_assigned_id;
   logic [ID_W-1:0]     rsp_restored_id;
   logic [ADDR_W-1:0]   rsp_restored_address;
   logic [PORT_W-1:0]   rsp_restored_port;
   logic [OCC_W-1:0]    rsp_occupancy;

   // Live mappings, oldest first, and the next id to hand out
   entry_type        live_map[$];
   logic [ID_W-1:0]  id_counter;
   outcome_type      owed_replies[$];

   int unsigned mismatch_count;
   int unsigned replies_checked;
   int unsigned inserts_done;
   int unsigned full_refusals;
   int unsigned releases_done;
   int unsigned release_misses;
   int unsigned cycle_count;

   // Idling limits per side and the long receiver hold-off
   int unsigned req_max_gap;
   int unsigned rsp_max_stall;
   int unsigned rsp_hold_cycles;
   bit          rsp_taken;

   transaction_id_remap_table dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_original_id      (req_original_id),
      .req_client_address   (req_client_address),
      .req_client_port      (req_client_port),
      .req_lookup_id        (req_lookup_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_assigned_id      (rsp_assigned_id),
      .rsp_restored_id      (rsp_restored_id),
      .rsp_restored_address (rsp_restored_address),
      .rsp_restored_port    (rsp_restored_port),
      .rsp_occupancy        (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abandon the run if it hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   // At least half of the draws give no idling at all
   function automatic int unsigned idle_draw(int unsigned limit);
      if (limit == 0 || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, limit);
   endfunction

   // Apply one request to the table copy and return the response it owes
   function automatic outcome_type apply_mapping_step(
      logic              command,
      logic [ID_W-1:0]   original_id,
      logic [ADDR_W-1:0] client_address,
      logic [PORT_W-1:0] client_port,
      logic [ID_W-1:0]   lookup_id
   );
      outcome_type result;
      entry_type   fresh;
      int          hit;
      result = '0;
      hit = -1;
      if (command == CMD_INSERT) begin
         if (live_map.size() >= TABLE_ENTRIES) begin
            result.status = STATUS_FULL;
            full_refusals++;
         end else begin
            fresh.mapped_id   = id_counter;
            fresh.original_id = original_id;
            fresh.address     = client_address;
            fresh.port        = client_port;
            live_map.push_back(fresh);
            result.status      = STATUS_OK;
            result.assigned_id = id_counter;
            id_counter = id_counter + 1'b1;
            inserts_done++;
         end
      end else begin
         // oldest match wins when ids repeat after a wrap
         foreach (live_map[i])
            if (hit < 0 && live_map[i].mapped_id == lookup_id)
               hit = i;
         if (hit < 0) begin
            result.status = STATUS_NOT_FOUND;
            release_misses++;
         end else begin
            result.status           = STATUS_OK;
            result.restored_id      = live_map[hit].original_id;
            result.restored_address = live_map[hit].address;
            result.restored_port    = live_map[hit].port;
            live_map.delete(hit);
            releases_done++;
         end
      end
      result.occupancy = OCC_W'(live_map.size());
      return result;
   endfunction

   // Offer one request and hold it until the transfer; valid stays high
   // until the next falling edge so a following request can go back to back
   task automatic send_item(
      input logic              command,
      input logic [ID_W-1:0]   original_id,
      input logic [ADDR_W-1:0] client_address,
      input logic [PORT_W-1:0] client_port,
      input logic [ID_W-1:0]   lookup_id
   );
      int unsigned gap;
      gap = idle_draw(req_max_gap);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= command;
      req_original_id    <= original_id;
      req_client_address <= client_address;
      req_client_port    <= client_port;
      req_lookup_id      <= lookup_id;
      do @(posedge clock); while (!req_ready);
      owed_replies.push_back(apply_mapping_step(command, original_id, client_address,
                                                client_port, lookup_id));
   endtask

   // Unused fields carry random values so every input bit toggles
   task automatic insert_client(input logic [ID_W-1:0] original_id,
                                input logic [ADDR_W-1:0] client_address,
                                input logic [PORT_W-1:0] client_port);
      send_item(CMD_INSERT, original_id, client_address, client_port, ID_W'($urandom));
   endtask

   task automatic release_id(input logic [ID_W-1:0] lookup_id);
      send_item(CMD_RELEASE, ID_W'($urandom), $urandom, PORT_W'($urandom), lookup_id);
   endtask

   // Drop valid and wait until every owed response has arrived
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed traffic: releases of live ids, some blind lookups
   task automatic random_step(input int unsigned insert_pct);
      if ($urandom_range(0, 99) < insert_pct)
         insert_client(ID_W'($urandom), $urandom, PORT_W'($urandom));
      else if (live_map.size() != 0 && $urandom_range(0, 9) != 0)
         release_id(live_map[$urandom_range(0, live_map.size() - 1)].mapped_id);
      else
         release_id(ID_W'($urandom));
   endtask

   // Field extremes, release misses and release from the middle
   task automatic test_directed_basics();
      release_id('0);
      insert_client('0, '0, '0);
      insert_client('1, '1, '1);
      insert_client(16'h1234, 32'hC0A8_0001, 16'd53);
      release_id(16'd1);
      release_id(16'd7);
      release_id('1);
      release_id(16'd0);
      release_id(16'd2);
      release_id(16'd2);
      insert_client(16'h8000, 32'h8000_0000, 16'h8000);
      release_id(id_counter - 1'b1);
      wait_idle();
   endtask

   // Fill the table, get refused, then release from middle, tail and head
   task automatic test_full_table();
      while (live_map.size() < TABLE_ENTRIES)
         insert_client(ID_W'($urandom), $urandom, PORT_W'($urandom));
      repeat (3) insert_client(ID_W'($urandom), $urandom, PORT_W'($urandom));
      release_id(live_map[TABLE_ENTRIES / 2].mapped_id);
      insert_client('1, '1, '1);
      insert_client('0, '0, '0);
      release_id(live_map[TABLE_ENTRIES - 1].mapped_id);
      release_id(live_map[0].mapped_id);
      while (live_map.size() != 0)
         release_id(live_map[$urandom_range(0, live_map.size() - 1)].mapped_id);
      wait_idle();
   endtask

   // Hold the response side off while requests keep coming
   task automatic test_response_backpressure();
      req_max_gap     = 0;
      rsp_max_stall   = 0;
      rsp_hold_cycles = 300;
      repeat (48) random_step(70);
      wait_idle();
   endtask

   // Random traffic in phases of differing fill bias and idling
   task automatic test_random_traffic();
      int unsigned insert_bias[6] = '{80, 50, 25, 65, 40, 90};
      int unsigned send_gaps[6]   = '{16, 0, 16, 0, 4, 16};
      int unsigned recv_stalls[6] = '{16, 0, 0, 16, 4, 16};
      for (int phase = 0; phase < 6; phase++) begin
         req_max_gap   = send_gaps[phase];
         rsp_max_stall = recv_stalls[phase];
         repeat (RANDOM_ITEMS / 6) random_step(insert_bias[phase]);
      end
      wait_idle();
   endtask

   // Receiver: draw a wait after each transfer, honour any long hold-off
   initial begin : response_receiver
      int unsigned rsp_wait;
      rsp_wait = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait = idle_draw(rsp_max_stall);
         end
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare every response transfer with the oldest owed outcome
   always @(posedge clock) begin : result_checker
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (owed_replies.size() == 0) begin
            $error("response with nothing owed: status %0d occupancy %0d",
                   rsp_status, rsp_occupancy);
            mismatch_count++;
         end else begin
            want = owed_replies.pop_front();
            replies_checked++;
            check_field("status", want.status, rsp_status);
            check_field("assigned_id", want.assigned_id, rsp_assigned_id);
            check_field("restored_id", want.restored_id, rsp_restored_id);
            check_field("restored_address", want.restored_address, rsp_restored_address);
            check_field("restored_port", want.restored_port, rsp_restored_port);
            check_field("occupancy", want.occupancy, rsp_occupancy);
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_INSERT;
      req_original_id    = '0;
      req_client_address = '0;
      req_client_port    = '0;
      req_lookup_id      = '0;
      id_counter         = '0;
      mismatch_count     = 0;
      replies_checked    = 0;
      inserts_done       = 0;
      full_refusals      = 0;
      releases_done      = 0;
      release_misses     = 0;
      req_max_gap        = 16;
      rsp_max_stall      = 16;
      rsp_hold_cycles    = 0;
      rsp_taken          = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_full_table();
      test_response_backpressure();
      test_random_traffic();

      mismatch_count += owed_replies.size();
      $display("Run covered %0d inserts, %0d refused on a full table, %0d releases, %0d misses",
               inserts_done, full_refusals, releases_done, release_misses);
      $display("Checked %0d response transfers", replies_checked);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: transaction_id_remap_table.f
rtl/core/tirt_pkg.sv
rtl/core/tirt_cell.sv
rtl/core/tirt_select.sv
rtl/core/transaction_id_remap_table.sv
test/testbench.sv
